/* sv/slvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slvc_pkg
// shared types and constants of the soft limit velocity command block
// ----------------------------------------------------------------------------
package slvc_pkg;

    localparam int VAL_W  = 32;
    localparam int VEL_W  = 16;
    localparam int ZONE_W = 3;
    localparam int CFG_W  = 3;

    localparam int DIV_STEPS = VAL_W + 16;
    localparam int MUL_STEPS = VAL_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic signed [VEL_W-1:0] VEL_TOP = 16'sd32767;

    localparam logic signed [VAL_W-1:0] RST_UPPER_LIMIT = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] RST_LOWER_LIMIT = 32'sh8000_0000;
    localparam logic [VAL_W-1:0]        RST_SCALE       = 32'd3754936321;

    typedef enum logic [ZONE_W-1:0] {
        ZONE_INSIDE     = 3'd0,
        ZONE_UPPER_SOFT = 3'd1,
        ZONE_UPPER_HARD = 3'd2,
        ZONE_LOWER_SOFT = 3'd3,
        ZONE_LOWER_HARD = 3'd4
    } zone_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_UPPER_SOFT = 3'd0,
        CFG_UPPER_HARD = 3'd1,
        CFG_LOWER_SOFT = 3'd2,
        CFG_LOWER_HARD = 3'd3,
        CFG_SCALE      = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_MUL,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

/* sv/slvc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slvc_in_if
// input channel: velocity reference and measured position
// ----------------------------------------------------------------------------
interface slvc_in_if;
    import slvc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] reference_velocity;
    logic signed [VAL_W-1:0] measured_position;

    modport source (
        output valid,
        input  ready,
        output reference_velocity,
        output measured_position
    );

    modport sink (
        input  valid,
        output ready,
        input  reference_velocity,
        input  measured_position
    );
endinterface
`default_nettype wire

/* sv/slvc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slvc_out_if
// output channel: drive velocity target and status
// ----------------------------------------------------------------------------
interface slvc_out_if;
    import slvc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] drive_velocity;
    logic                    send_needed;
    logic [ZONE_W-1:0]       limit_zone;
    logic                    saturated;

    modport source (
        output valid,
        input  ready,
        output drive_velocity,
        output send_needed,
        output limit_zone,
        output saturated
    );

    modport sink (
        input  valid,
        output ready,
        input  drive_velocity,
        input  send_needed,
        input  limit_zone,
        input  saturated
    );
endinterface
`default_nettype wire

/* sv/soft_limit_velocity_command.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_limit_velocity_command
// soft limit repulsion, scaling and saturation of a drive velocity target
// ----------------------------------------------------------------------------
// channel   dir  beat
// cmd       in   reference_velocity, measured_position (Q15.16)
// result    out  drive_velocity, send_needed, limit_zone, saturated
// cfg_*     in   register write: index, 32-bit data
//
// one item at a time through a bit-serial divider and shift-add multiplier
// hard zone: straight to the final step; inside: sum, multiply, final step
// soft zone: 48-step restoring divide, sum, 33-step multiply, final step
// a new beat is taken while a finished result still waits on result
// rst_n clears control state, last sent target and registers to defaults
// ----------------------------------------------------------------------------
module soft_limit_velocity_command (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    slvc_in_if.sink                            cmd,
    slvc_out_if.source                         result,
    input  wire logic                          cfg_we,
    input  wire logic [slvc_pkg::CFG_W-1:0]    cfg_index,
    input  wire logic [slvc_pkg::VAL_W-1:0]    cfg_data
);
    import slvc_pkg::*;

    state_t state_reg, state_next;

    logic signed [VAL_W-1:0] usoft_reg, uhard_reg, lsoft_reg, lhard_reg;
    logic [VAL_W-1:0]        scale_reg;

    logic signed [VAL_W-1:0] ref_reg, ref_next;
    zone_t                   zone_reg, zone_next;
    logic [DIV_STEPS-1:0]    dvd_reg, dvd_next;
    logic [DIV_STEPS-1:0]    quo_reg, quo_next;
    logic [VAL_W-1:0]        dsr_reg, dsr_next;
    logic [VAL_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [2*VAL_W:0]        prod_reg, prod_next;
    logic                    neg_reg, neg_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VEL_W-1:0] out_vel_reg, out_vel_next;
    logic                    out_send_reg, out_send_next;
    zone_t                   out_zone_reg, out_zone_next;
    logic                    out_sat_reg, out_sat_next;
    logic signed [VEL_W-1:0] last_sent_reg, last_sent_next;

    logic accept;
    logic out_free;
    logic load;

    // input side zone decode
    logic signed [VAL_W-1:0] pos;
    logic [VAL_W-1:0]        up_num, up_den, lo_num, lo_den;
    zone_t                   zone_in;

    // divider step
    logic [VAL_W:0]          rem_shift;
    logic                    rem_ge;

    // offset and sum
    logic [VAL_W:0]          off_mag;
    logic signed [VAL_W+1:0] off;
    logic signed [VAL_W+1:0] sum;
    logic [VAL_W+1:0]        sum_abs;

    // multiply step
    logic [VAL_W:0]          mul_add;

    // final target
    logic [2*VAL_W-1:0]      prod;
    logic                    over;
    logic signed [VEL_W-1:0] whole;
    logic signed [VEL_W-1:0] target;
    logic                    target_sat;

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign load     = (state_reg == ST_FIN) && out_free;

    assign pos    = cmd.measured_position;
    assign up_num = VAL_W'({pos[VAL_W-1], pos} - {usoft_reg[VAL_W-1], usoft_reg});
    assign up_den = VAL_W'({uhard_reg[VAL_W-1], uhard_reg} - {pos[VAL_W-1], pos});
    assign lo_num = VAL_W'({lsoft_reg[VAL_W-1], lsoft_reg} - {pos[VAL_W-1], pos});
    assign lo_den = VAL_W'({pos[VAL_W-1], pos} - {lhard_reg[VAL_W-1], lhard_reg});

    always_comb
    begin
        priority if (pos > usoft_reg)
        begin
            zone_in = (pos >= uhard_reg) ? ZONE_UPPER_HARD : ZONE_UPPER_SOFT;
        end
        else if (pos < lsoft_reg)
        begin
            zone_in = (pos <= lhard_reg) ? ZONE_LOWER_HARD : ZONE_LOWER_SOFT;
        end
        else
        begin
            zone_in = ZONE_INSIDE;
        end
    end

    assign rem_shift = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign rem_ge    = rem_shift >= {1'b0, dsr_reg};

    // quotient clamp to the Q15.16 range
    always_comb
    begin
        unique case (zone_reg)
            ZONE_UPPER_SOFT:
            begin
                off_mag = (quo_reg > DIV_STEPS'(33'h1_0000_0000 >> 1))
                        ? (VAL_W+1)'(33'h0_8000_0000) : quo_reg[VAL_W:0];
                off     = -$signed({1'b0, off_mag});
            end
            ZONE_LOWER_SOFT:
            begin
                off_mag = (quo_reg > DIV_STEPS'(33'h0_7FFF_FFFF))
                        ? (VAL_W+1)'(33'h0_7FFF_FFFF) : quo_reg[VAL_W:0];
                off     = $signed({1'b0, off_mag});
            end
            default:
            begin
                off_mag = '0;
                off     = '0;
            end
        endcase
    end

    assign sum     = $signed({{2{ref_reg[VAL_W-1]}}, ref_reg}) + off;
    assign sum_abs = sum[VAL_W+1] ? (VAL_W+2)'(-sum) : sum;

    assign mul_add = {1'b0, prod_reg[2*VAL_W:VAL_W+1]}
                   + (prod_reg[0] ? {1'b0, scale_reg} : '0);

    assign prod  = prod_reg[2*VAL_W-1:0];
    assign over  = prod > {32'(VEL_TOP), 32'd0};
    assign whole = over ? VEL_TOP : $signed({1'b0, prod[VAL_W+VEL_W-2:VAL_W]});

    always_comb
    begin
        unique case (zone_reg)
            ZONE_UPPER_HARD:
            begin
                target     = -VEL_TOP;
                target_sat = 1'b1;
            end
            ZONE_LOWER_HARD:
            begin
                target     = VEL_TOP;
                target_sat = 1'b1;
            end
            default:
            begin
                target     = neg_reg ? -whole : whole;
                target_sat = over;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (zone_in)
                        ZONE_UPPER_HARD, ZONE_LOWER_HARD: state_next = ST_FIN;
                        ZONE_UPPER_SOFT, ZONE_LOWER_SOFT: state_next = ST_DIV;
                        default:                          state_next = ST_SUM;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        ref_next  = ref_reg;
        zone_next = zone_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        neg_next  = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ref_next  = cmd.reference_velocity;
                zone_next = zone_in;
                dvd_next  = {(zone_in == ZONE_LOWER_SOFT) ? lo_num : up_num, 16'd0};
                dsr_next  = (zone_in == ZONE_LOWER_SOFT) ? lo_den : up_den;
                quo_next  = '0;
                rem_next  = '0;
                cnt_next  = '0;
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? VAL_W'(rem_shift - {1'b0, dsr_reg}) : rem_shift[VAL_W-1:0];
                quo_next = {quo_reg[DIV_STEPS-2:0], rem_ge};
                dvd_next = {dvd_reg[DIV_STEPS-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_SUM:
            begin
                neg_next  = sum[VAL_W+1];
                prod_next = {(VAL_W)'(0), sum_abs[VAL_W:0]};
                cnt_next  = '0;
            end
            ST_MUL:
            begin
                prod_next = {mul_add, prod_reg[VAL_W:1]};
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_vel_next   = out_vel_reg;
        out_send_next  = out_send_reg;
        out_zone_next  = out_zone_reg;
        out_sat_next   = out_sat_reg;
        last_sent_next = last_sent_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            out_vel_next   = target;
            out_send_next  = (target != last_sent_reg);
            out_zone_next  = zone_reg;
            out_sat_next   = target_sat;
            last_sent_next = target;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.drive_velocity = out_vel_reg;
    assign result.send_needed    = out_send_reg;
    assign result.limit_zone     = out_zone_reg;
    assign result.saturated      = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_sent_reg <= '0;
            usoft_reg     <= RST_UPPER_LIMIT;
            uhard_reg     <= RST_UPPER_LIMIT;
            lsoft_reg     <= RST_LOWER_LIMIT;
            lhard_reg     <= RST_LOWER_LIMIT;
            scale_reg     <= RST_SCALE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_sent_reg <= last_sent_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_UPPER_SOFT: usoft_reg <= cfg_data;
                    CFG_UPPER_HARD: uhard_reg <= cfg_data;
                    CFG_LOWER_SOFT: lsoft_reg <= cfg_data;
                    CFG_LOWER_HARD: lhard_reg <= cfg_data;
                    CFG_SCALE:      scale_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg      <= ref_next;
        zone_reg     <= zone_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        dsr_reg      <= dsr_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        out_vel_reg  <= out_vel_next;
        out_send_reg <= out_send_next;
        out_zone_reg <= out_zone_next;
        out_sat_reg  <= out_sat_next;
    end

`ifndef SYNTH
    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result beat raised outside the final step");

    a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

    a_hard_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_zone_reg == ZONE_UPPER_HARD)
        |-> (out_vel_reg == -VEL_TOP && out_sat_reg))
        else $error("upper hard zone target wrong");

    a_last_sent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_sent_reg == out_vel_reg))
        else $error("last sent target out of step with result");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for soft_limit_velocity_command: a directed pass over
// the limit zones, offset saturation and the product boundary, then random
// phases over limit settings, scale factors and handshake idling; every
// result beat is checked against a predicted drive target
// ----------------------------------------------------------------------------
module tb_top;
    import slvc_pkg::*;

    typedef struct {
        logic signed [VEL_W-1:0] drive_velocity;
        logic                    send_needed;
        zone_t                   limit_zone;
        logic                    saturated;
    } target_t;

    typedef enum {
        LIM_ORDERED,
        LIM_INVERTED,
        LIM_WILD,
        LIM_EXTREME
    } limit_kind_t;

    class target_tracker;
        longint                  upper_soft;
        longint                  upper_hard;
        longint                  lower_soft;
        longint                  lower_hard;
        longint unsigned         scale;
        logic signed [VEL_W-1:0] last_sent;
        target_t                 expected_q[$];
        int                      mismatches;

        function new();
            upper_soft = 64'(RST_UPPER_LIMIT);
            upper_hard = 64'(RST_UPPER_LIMIT);
            lower_soft = 64'(RST_LOWER_LIMIT);
            lower_hard = 64'(RST_LOWER_LIMIT);
            scale      = 64'(RST_SCALE);
            last_sent  = '0;
            mismatches = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [VAL_W-1:0] data);
            logic signed [VAL_W-1:0] sdata;
            sdata = data;
            case (idx)
                CFG_UPPER_SOFT: upper_soft = 64'(sdata);
                CFG_UPPER_HARD: upper_hard = 64'(sdata);
                CFG_LOWER_SOFT: lower_soft = 64'(sdata);
                CFG_LOWER_HARD: lower_hard = 64'(sdata);
                CFG_SCALE:      scale = 64'(data);
                default: ;
            endcase
        endfunction

        function target_t predict_target(logic signed [VAL_W-1:0] vel_in,
                                         logic signed [VAL_W-1:0] pos_in);
            longint          pos;
            longint          offset;
            longint          sum;
            longint unsigned num;
            longint unsigned den;
            longint unsigned quot;
            longint unsigned mag;
            longint unsigned prod;
            logic            neg;
            int              whole;
            target_t         t;
            pos          = 64'(pos_in);
            offset       = 0;
            t.limit_zone = ZONE_INSIDE;
            t.saturated  = 1'b0;
            if (pos > upper_soft)
            begin
                if (pos >= upper_hard)
                begin
                    t.limit_zone = ZONE_UPPER_HARD;
                end
                else
                begin
                    num  = pos - upper_soft;
                    den  = upper_hard - pos;
                    quot = (num << 16) / den;
                    if (quot > 64'h8000_0000)
                        quot = 64'h8000_0000;
                    offset = quot;
                    offset = -offset;
                    t.limit_zone = ZONE_UPPER_SOFT;
                end
            end
            else if (pos < lower_soft)
            begin
                if (pos <= lower_hard)
                begin
                    t.limit_zone = ZONE_LOWER_HARD;
                end
                else
                begin
                    num  = lower_soft - pos;
                    den  = pos - lower_hard;
                    quot = (num << 16) / den;
                    if (quot > 64'h7FFF_FFFF)
                        quot = 64'h7FFF_FFFF;
                    offset = quot;
                    t.limit_zone = ZONE_LOWER_SOFT;
                end
            end

            if (t.limit_zone == ZONE_UPPER_HARD)
            begin
                t.drive_velocity = -VEL_TOP;
                t.saturated      = 1'b1;
            end
            else if (t.limit_zone == ZONE_LOWER_HARD)
            begin
                t.drive_velocity = VEL_TOP;
                t.saturated      = 1'b1;
            end
            else
            begin
                sum  = 64'(vel_in) + offset;
                neg  = (sum < 0);
                mag  = neg ? -sum : sum;
                prod = mag * scale;
                if (prod > (64'd32767 << 32))
                begin
                    whole       = 32767;
                    t.saturated = 1'b1;
                end
                else
                begin
                    whole = 32'(prod >> 32);
                end
                t.drive_velocity = VEL_W'(neg ? -whole : whole);
            end
            t.send_needed = (t.drive_velocity != last_sent);
            last_sent     = t.drive_velocity;
            return t;
        endfunction

        function void note_command(logic signed [VAL_W-1:0] vel_in,
                                   logic signed [VAL_W-1:0] pos_in);
            expected_q.push_back(predict_target(vel_in, pos_in));
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        function void check_target(logic signed [VEL_W-1:0] vel, logic send,
                                   logic [ZONE_W-1:0] zone, logic sat);
            target_t exp;
            if (expected_q.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat vel %0d send %0b zone %0d sat %0b",
                                        vel, send, zone, sat));
                return;
            end
            exp = expected_q.pop_front();
            if (vel !== exp.drive_velocity || send !== exp.send_needed ||
                zone !== exp.limit_zone || sat !== exp.saturated)
                note_mismatch($sformatf(
                    "exp vel %0d send %0b zone %0d sat %0b, got vel %0d send %0b zone %0d sat %0b",
                    exp.drive_velocity, exp.send_needed, exp.limit_zone, exp.saturated,
                    vel, send, zone, sat));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_index;
    logic [VAL_W-1:0]   cfg_data;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_request = 0;
    target_tracker      tracker = new();

    slvc_in_if  cmd_if();
    slvc_out_if res_if();

    soft_limit_velocity_command u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #16ms;
        $display("soft_limit_velocity_command verification failed");
        $finish;
    end

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                res_if.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                res_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                tracker.check_target(res_if.drive_velocity, res_if.send_needed,
                                     res_if.limit_zone, res_if.saturated);
        end
    end

    function automatic logic signed [VAL_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] random_velocity();
        logic signed [VAL_W-1:0] v;
        if ($urandom_range(3) == 0)
            return $urandom;
        v = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // positions cluster around the configured limits
    function automatic logic signed [VAL_W-1:0] random_position();
        longint base;
        longint delta;
        int     pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return $urandom;
        case (pick % 4)
            0:       base = tracker.upper_soft;
            1:       base = tracker.upper_hard;
            2:       base = tracker.lower_soft;
            default: base = tracker.lower_hard;
        endcase
        if (pick >= 8)
        begin
            delta = 64'($urandom_range(6));
            delta = delta - 3;
        end
        else
        begin
            delta = 64'($urandom >> $urandom_range(31, 4));
            if ($urandom_range(1))
                delta = -delta;
        end
        return clamp32(base + delta);
    endfunction

    task automatic send_item(logic signed [VAL_W-1:0] vel, logic signed [VAL_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_if.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        cmd_if.valid              = 1'b1;
        cmd_if.reference_velocity = vel;
        cmd_if.measured_position  = pos;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        tracker.note_command(vel, pos);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        cmd_if.valid = 1'b0;
        @(posedge clk);
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [VAL_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        tracker.set_register(idx, data);
    endtask

    task automatic configure(logic signed [VAL_W-1:0] us, logic signed [VAL_W-1:0] uh,
                             logic signed [VAL_W-1:0] ls, logic signed [VAL_W-1:0] lh,
                             logic [VAL_W-1:0] scale);
        write_register(CFG_UPPER_SOFT, us);
        write_register(CFG_UPPER_HARD, uh);
        write_register(CFG_LOWER_SOFT, ls);
        write_register(CFG_LOWER_HARD, lh);
        write_register(CFG_SCALE, scale);
        @(posedge clk);
    endtask

    task automatic random_setup(limit_kind_t kind, logic [VAL_W-1:0] scale);
        longint us;
        longint uh;
        longint ls;
        longint lh;
        longint span_u;
        longint span_l;
        span_u = 64'($urandom >> $urandom_range(31, 2));
        span_u = span_u + 1;
        span_l = 64'($urandom >> $urandom_range(31, 2));
        span_l = span_l + 1;
        us     = 64'($urandom_range(1 << 24));
        ls     = 64'($urandom_range(1 << 24));
        ls     = -ls;
        case (kind)
            LIM_ORDERED:
            begin
                uh = us + span_u;
                lh = ls - span_l;
            end
            LIM_INVERTED:
            begin
                uh = us - span_u;
                lh = ls + span_l;
            end
            LIM_WILD:
            begin
                us = 64'($signed($urandom));
                uh = 64'($signed($urandom));
                ls = 64'($signed($urandom));
                lh = 64'($signed($urandom));
            end
            default:
            begin
                us = -64'sd2147483648;
                uh = 64'sd2147483647;
                ls = 64'sd2147483647;
                lh = -64'sd2147483648;
            end
        endcase
        configure(clamp32(us), clamp32(uh), clamp32(ls), clamp32(lh), scale);
    endtask

    initial
    begin
        int saved_idle;
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = CFG_UPPER_SOFT;
        cfg_data                  = '0;
        cmd_if.valid              = 1'b0;
        cmd_if.reference_velocity = '0;
        cmd_if.measured_position  = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset limits: every position inside, default scale
        send_item(32'sh0000_0000, 32'sh0000_0000);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh0000_0001, 32'sh0000_0000);
        send_item(32'sh0000_0008, -32'sh0000_0001);
        wait_results_done();

        configure(32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, -32'sh0002_0000,
                  32'h0001_0000);
        send_item(32'sh0000_0000, 32'sh0001_0000);
        send_item(32'sh0000_0000, 32'sh0001_0001);
        send_item(32'sh4000_0000, 32'sh0001_8000);
        send_item(32'sh0000_0000, 32'sh0001_FFFF);
        send_item(32'sh7FFF_FFFF, 32'sh0001_FFFF);
        send_item(32'sh0000_0000, 32'sh0002_0000);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(32'sh0000_0000, -32'sh0001_0000);
        send_item(32'sh0000_0000, -32'sh0001_0001);
        send_item(32'sh0000_0000, -32'sh0001_FFFF);
        send_item(32'sh8000_0000, -32'sh0001_FFFF);
        send_item(32'sh0000_0000, -32'sh0002_0000);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(32'sh7FFF_0000, 32'sh0000_0000);
        send_item(32'sh7FFF_0001, 32'sh0000_0000);
        send_item(-32'sh7FFF_0000, 32'sh0000_0000);
        send_item(-32'sh7FFF_0000, 32'sh0000_0000);
        wait_results_done();

        // upper hard limit inside upper soft limit, lower soft above upper soft
        configure(32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000, 32'sh0001_8000,
                  32'hFFFF_FFFF);
        send_item(32'sh0000_0100, 32'sh0001_0001);
        send_item(32'sh0000_0100, 32'sh0001_0000);
        send_item(32'sh0000_0100, 32'sh0001_9000);
        send_item(32'sh0000_0100, 32'sh0000_8000);
        wait_results_done();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       random_setup(LIM_ORDERED, $urandom >> $urandom_range(31, 8));
                1:       random_setup(LIM_ORDERED, $urandom);
                2:       random_setup(LIM_WILD, $urandom >> $urandom_range(31, 0));
                3:       random_setup(LIM_INVERTED, 32'h0000_0000);
                4:       random_setup(LIM_EXTREME, 32'hFFFF_FFFF);
                5:       random_setup(LIM_ORDERED, 32'h0001_0000);
                6:       random_setup(LIM_WILD, $urandom);
                default: random_setup(LIM_ORDERED, $urandom >> $urandom_range(31, 12));
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase

            // long result hold-off while commands keep coming
            @(posedge clk);
            hold_request  = 300;
            saved_idle    = send_idle_pct;
            send_idle_pct = 0;
            repeat (12) send_item(random_velocity(), random_position());
            send_idle_pct = saved_idle;

            for (int n = 0; n < 178; n++)
            begin
                if (n == 89)
                    wait_results_done();
                send_item(random_velocity(), random_position());
            end
            wait_results_done();
        end

        repeat (100) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
            $display("soft_limit_velocity_command verification clean");
        else
            $display("soft_limit_velocity_command verification failed");
        $finish;
    end

endmodule
